// ----- rtl/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants, types and state codes of the transitive closure engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  // Node count of the graph; rows and result count are capped at 16
  localparam int NODES     = 16;
  localparam int MAX_ROWS  = 16;
  localparam int EFF_NODES = (NODES < MAX_ROWS) ? NODES : MAX_ROWS;
  localparam int ROW_W     = EFF_NODES;
  localparam int IDX_W     = (EFF_NODES > 1) ? $clog2(EFF_NODES) : 1;

  // Fixed port widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_ROW_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EFF_NODES - 1);

  typedef logic [ROW_W-1:0]                 row_t;
  typedef row_t [EFF_NODES-1:0]             rows_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

  // Broadcast from the sequencer to every lane during a closure step
  typedef struct packed {
    logic             close_en;
    logic [IDX_W-1:0] k;
    row_t             pivot;
  } lane_ctrl_t;

endpackage

// ----- rtl/tce_lane.sv -----
// ----------------------------------------------------------------------------
// tce_lane
// One matrix row: loads its adjacency row, then ORs in the pivot row on
// every closure step whose pivot bit it has set.
// ----------------------------------------------------------------------------
module tce_lane (
  input  logic                clk,
  input  logic                wr_en,
  input  tce_pkg::row_t       wr_data,
  input  tce_pkg::lane_ctrl_t ctrl,
  output tce_pkg::row_t       row
);
  import tce_pkg::*;

  row_t row_r;
  row_t row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (wr_en) begin
      row_nxt = wr_data;
    end else if (ctrl.close_en && row_r[ctrl.k]) begin
      row_nxt = row_r | ctrl.pivot;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row = row_r;

endmodule

// ----- rtl/tce_merge.sv -----
// ----------------------------------------------------------------------------
// tce_merge
// Gathers the lane rows: picks the pivot row during closure and the
// outgoing row during emit.
// ----------------------------------------------------------------------------
module tce_merge (
  input  tce_pkg::rows_t              rows,
  input  logic [tce_pkg::IDX_W-1:0]   sel,
  output tce_pkg::row_t               row
);
  import tce_pkg::*;

  always_comb begin
    row = '0;
    for (int i = 0; i < EFF_NODES; i++) begin
      if (sel == IDX_W'(i)) begin
        row = rows[i];
      end
    end
  end

endmodule

// ----- rtl/transitive_closure_engine.sv -----
// ----------------------------------------------------------------------------
// transitive_closure_engine
// Warshall transitive closure of a 16-node boolean graph, row-parallel lanes.
// ----------------------------------------------------------------------------
// Send the adjacency matrix one row per input word, row 0 first; bits beyond
// the node count are dropped. The block stores one row per lane. After the
// last row it runs one closure step per node (step k: every lane whose bit k
// is set ORs in row k, all lanes at once), then emits the closed rows in
// order on the output stream, each word tagged with its row index, with
// tlast on the final row. The closure runs one pivot step per cycle.
// Input is held off while closing and emitting; the output word sits in
// a register, so the next matrix may start loading while the final row
// still waits to be taken.
module transitive_closure_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] row_bits
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tce_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: [3:0] row_index, [19:4] closure_bits, [23:20] zero
  // out_tlast: last_row
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tce_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);
  import tce_pkg::*;

  // Sequencer state; cnt_r is load row, pivot k or emit row by state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  // Output word register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_last_r;

  logic       in_fire;
  logic       out_load;   // out register free for a new word
  logic       emit_word;
  rows_t      rows;
  row_t       sel_row;
  lane_ctrl_t ctrl;
  row_t       wr_data;

  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;
  assign wr_data   = in_tdata[ROW_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_CLOSE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready     = 1'b0;
    emit_word     = 1'b0;
    ctrl.close_en = 1'b0;
    ctrl.k        = cnt_r;
    ctrl.pivot    = sel_row;
    unique case (state_r)
      ST_LOAD:  in_tready     = 1'b1;
      ST_CLOSE: ctrl.close_en = 1'b1;
      ST_EMIT:  emit_word     = out_load;
      default:  in_tready     = 1'b0;
    endcase
  end

  // Row lanes
  for (genvar i = 0; i < EFF_NODES; i++) begin : g_lane
    tce_lane u_lane (
      .clk     (clk),
      .wr_en   (in_fire && (cnt_r == IDX_W'(i))),
      .wr_data (wr_data),
      .ctrl    (ctrl),
      .row     (rows[i])
    );
  end

  // Pivot / emit row select
  tce_merge u_merge (
    .rows (rows),
    .sel  (cnt_r),
    .row  (sel_row)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_word) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (emit_word) begin
      out_idx_r  <= OUT_IDX_W'(cnt_r);
      out_row_r  <= OUT_ROW_W'(sel_row);
      out_last_r <= (cnt_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_ROW_W - OUT_IDX_W){1'b0}}, out_row_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/tce_checker.sv -----
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks of the transitive closure engine, bound to the top.
// ----------------------------------------------------------------------------
module tce_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tce_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import tce_pkg::*;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Input is held off while a matrix is still being emitted
  a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted during emit");

  // Final row carries the last index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[OUT_IDX_W-1:0] == OUT_IDX_W'(LAST_IDX))
    else $error("tlast on wrong row");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_IDX_W+OUT_ROW_W] == '0)
    else $error("nonzero padding in output word");

endmodule

bind transitive_closure_engine tce_checker u_tce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
